FILE: design/mie_pkg.sv
// shared types and opcode constants for the integer alu execute block
package mie_pkg;

    localparam int unsigned XLEN       = 32;
    localparam int unsigned REG_COUNT  = 32;
    localparam int unsigned REG_AW     = 5;

    // primary opcode field, instruction bits 31:26
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;
    localparam logic [5:0] OP_LUI     = 6'h0F;

    // function field of the special group, instruction bits 5:0
    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_XOR  = 6'h26;

    // one executed instruction as reported on the result channel
    typedef struct packed {
        logic              unsupported;
        logic              overflow_trap;
        logic              dest_written;
        logic [XLEN-1:0]   dest_value;
        logic [REG_AW-1:0] dest_index;
    } exec_result_t;

    // register file write port
    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [XLEN-1:0]   data;
    } wr_port_t;

    // register file read request
    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr_a;
        logic [REG_AW-1:0] addr_b;
    } rd_port_t;

endpackage

FILE: design/mie_regfile.sv
// 32-entry register file with registered reads, write bypass and per-entry valid bits
module mie_regfile (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  mie_pkg::rd_port_t       rd,
    input  mie_pkg::wr_port_t       wr,
    output logic [mie_pkg::XLEN-1:0] rdata_a,
    output logic [mie_pkg::XLEN-1:0] rdata_b
);
    import mie_pkg::*;

    logic [XLEN-1:0]      mem [REG_COUNT];
    logic [REG_COUNT-1:0] vld_reg;
    logic [XLEN-1:0]      a_reg;
    logic [XLEN-1:0]      b_reg;
    logic                 a_vld_reg;
    logic                 b_vld_reg;

    // storage write
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // valid bits, cleared by reset so unwritten entries read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr.en) begin
            vld_reg[wr.addr] <= 1'b1;
        end
    end

    // registered read, a write in the same cycle passes straight through
    always_ff @(posedge aclk) begin
        if (rd.en) begin
            if (wr.en && (wr.addr == rd.addr_a)) begin
                a_reg     <= wr.data;
                a_vld_reg <= 1'b1;
            end else begin
                a_reg     <= mem[rd.addr_a];
                a_vld_reg <= vld_reg[rd.addr_a];
            end
            if (wr.en && (wr.addr == rd.addr_b)) begin
                b_reg     <= wr.data;
                b_vld_reg <= 1'b1;
            end else begin
                b_reg     <= mem[rd.addr_b];
                b_vld_reg <= vld_reg[rd.addr_b];
            end
        end
    end

    assign rdata_a = a_vld_reg ? a_reg : '0;
    assign rdata_b = b_vld_reg ? b_reg : '0;

endmodule

FILE: design/mie_alu.sv
// instruction decode and combinational integer execute
module mie_alu (
    input  logic [mie_pkg::XLEN-1:0] instruction,
    input  logic [mie_pkg::XLEN-1:0] op_a,
    input  logic [mie_pkg::XLEN-1:0] op_b,
    output mie_pkg::exec_result_t    result
);
    import mie_pkg::*;

    logic [5:0]        opcode;
    logic [5:0]        funct;
    logic [REG_AW-1:0] rt;
    logic [REG_AW-1:0] rd;
    logic [4:0]        sa;
    logic [15:0]       imm;
    logic [XLEN-1:0]   uimm;
    logic [XLEN-1:0]   simm;
    logic [XLEN-1:0]   val;
    logic [REG_AW-1:0] dest;
    logic              ovf;
    logic              ok;

    // instruction fields
    assign opcode = instruction[31:26];
    assign rt     = instruction[20:16];
    assign rd     = instruction[15:11];
    assign sa     = instruction[10:6];
    assign funct  = instruction[5:0];
    assign imm    = instruction[15:0];
    assign uimm   = {16'h0000, imm};
    assign simm   = {{16{imm[15]}}, imm};

    // operation select
    always_comb begin
        val  = '0;
        ovf  = 1'b0;
        ok   = 1'b1;
        dest = rt;
        if (opcode == OP_SPECIAL) begin
            dest = rd;
            case (funct)
                FN_SLL: begin
                    val = op_b << sa;
                end
                FN_ADD: begin
                    val = op_a + op_b;
                    ovf = ((op_a[31] ^ val[31]) & (op_b[31] ^ val[31]));
                end
                FN_ADDU: begin
                    val = op_a + op_b;
                end
                FN_SUB: begin
                    val = op_a - op_b;
                    ovf = ((op_a[31] ^ op_b[31]) & (op_a[31] ^ val[31]));
                end
                FN_SUBU: begin
                    val = op_a - op_b;
                end
                FN_AND: begin
                    val = op_a & op_b;
                end
                FN_OR: begin
                    val = op_a | op_b;
                end
                FN_XOR: begin
                    val = op_a ^ op_b;
                end
                default: begin
                    ok = 1'b0;
                end
            endcase
        end else begin
            case (opcode)
                OP_ADDI: begin
                    val = op_a + simm;
                    ovf = ((op_a[31] ^ val[31]) & (simm[31] ^ val[31]));
                end
                OP_ADDIU: begin
                    val = op_a + simm;
                end
                OP_ANDI: begin
                    val = op_a & uimm;
                end
                OP_ORI: begin
                    val = op_a | uimm;
                end
                OP_XORI: begin
                    val = op_a ^ uimm;
                end
                OP_LUI: begin
                    val = {imm, 16'h0000};
                end
                default: begin
                    ok = 1'b0;
                end
            endcase
        end
    end

    // report: unsupported clears everything, trap or r0 suppresses the write
    always_comb begin
        result = '0;
        if (!ok) begin
            result.unsupported = 1'b1;
        end else begin
            result.dest_index    = dest;
            result.overflow_trap = ovf;
            result.dest_written  = !ovf && (dest != '0);
            result.dest_value    = result.dest_written ? val : '0;
        end
    end

endmodule

FILE: design/mips_integer_alu_execute_top.sv
// top level of the integer alu execute block: operand fetch, execute and result register
// instruction and operands are registered on accept, the result when the stage advances
// one instruction per cycle unless the output stalls; the register file read sits in the
// accept cycle, the write lands as the result is registered, with a bypass between the two
// reset: aresetn clears the pipeline valid flags and the register file valid bits,
// so every register reads as zero after reset; no clearing pass is needed
module mips_integer_alu_execute_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] instruction
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [4:0] dest_index, [36:5] dest_value,
                                   // [37] dest_written, [38] overflow_trap, [39] unsupported
);
    import mie_pkg::*;

    logic            s_accept;
    logic            advance;
    logic            ex_valid_reg;
    logic            ex_valid_next;
    logic [XLEN-1:0] instr_reg;
    logic            out_valid_reg;
    logic            out_valid_next;
    exec_result_t    out_res_reg;
    exec_result_t    ex_res;
    rd_port_t        rf_rd;
    wr_port_t        rf_wr;
    logic [XLEN-1:0] op_a;
    logic [XLEN-1:0] op_b;

    // handshake and stage advance
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !ex_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    // operand read on accept, write back as the result is registered
    assign rf_rd.en     = s_accept;
    assign rf_rd.addr_a = s_tdata[25:21];
    assign rf_rd.addr_b = s_tdata[20:16];
    assign rf_wr.en     = advance && ex_valid_reg && ex_res.dest_written;
    assign rf_wr.addr   = ex_res.dest_index;
    assign rf_wr.data   = ex_res.dest_value;

    mie_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd      (rf_rd),
        .wr      (rf_wr),
        .rdata_a (op_a),
        .rdata_b (op_b)
    );

    mie_alu u_alu (
        .instruction (instr_reg),
        .op_a        (op_a),
        .op_b        (op_b),
        .result      (ex_res)
    );

    // valid flags of the execute and output stages
    always_comb begin
        ex_valid_next = ex_valid_reg;
        if (s_accept) begin
            ex_valid_next = 1'b1;
        end else if (advance) begin
            ex_valid_next = 1'b0;
        end
        out_valid_next = advance ? ex_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            ex_valid_reg  <= ex_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            instr_reg <= s_tdata;
        end
        if (advance && ex_valid_reg) begin
            out_res_reg <= ex_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_res_reg;

`ifndef SYNTHESIS
    // a stalled execute stage must hold off new input
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (ex_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while execute stage is stalled");

    // register zero is never written
    a_no_r0_write: assert property (@(posedge aclk) disable iff (!aresetn)
        rf_wr.en |-> (rf_wr.addr != '0))
        else $error("write to register zero");

    // a trap never writes
    a_trap_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res_reg.overflow_trap) |-> !out_res_reg.dest_written)
        else $error("trapping instruction reported a write");

    // an unsupported instruction reports nothing else
    a_unsup_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_res_reg.unsupported) |->
            (!out_res_reg.dest_written && !out_res_reg.overflow_trap &&
             (out_res_reg.dest_value == '0) && (out_res_reg.dest_index == '0)))
        else $error("unsupported instruction with nonzero result fields");

    // every register file write comes from a result entering the output register
    a_write_follows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        rf_wr.en |=> (out_valid_reg && out_res_reg.dest_written))
        else $error("register write without a matching result");
`endif

endmodule

FILE: test/mips_integer_alu_execute_top_tb.sv
// self-checking testbench for the integer alu execute block with a register file predictor
`timescale 1ns / 1ps

module mips_integer_alu_execute_top_tb;
    import mie_pkg::*;

    // codes outside the implemented subset, used to hit the unsupported path
    localparam logic [5:0] OP_LW          = 6'h23;
    localparam logic [5:0] FN_UNASSIGNED  = 6'h3F;
    localparam int unsigned RANDOM_ITEMS  = 830;
    localparam int unsigned DRAIN_LIMIT   = 5000;

    // expected-result store and register file predictor
    class alu_scoreboard;
        logic [XLEN-1:0] regs [REG_COUNT];
        exec_result_t    pending_results [$];
        int unsigned     errors;
        int unsigned     n_instructions;
        int unsigned     n_results;
        int unsigned     n_traps;
        int unsigned     n_unsupported;
        int unsigned     n_writes;

        function new();
            foreach (regs[i]) regs[i] = '0;
            errors = 0;
            n_instructions = 0;
            n_results = 0;
            n_traps = 0;
            n_unsupported = 0;
            n_writes = 0;
        endfunction

        // execute one instruction word against the predicted register file
        function exec_result_t execute(logic [31:0] ins);
            logic [5:0]        opcode;
            logic [5:0]        funct;
            logic [REG_AW-1:0] rs, rt, rd, sa, dest;
            logic [XLEN-1:0]   a, b, uimm, simm, val;
            logic              ovf, ok, wr;
            exec_result_t      r;
            opcode = ins[31:26];
            funct  = ins[5:0];
            rs     = ins[25:21];
            rt     = ins[20:16];
            rd     = ins[15:11];
            sa     = ins[10:6];
            uimm   = {16'h0000, ins[15:0]};
            simm   = {{16{ins[15]}}, ins[15:0]};
            a      = regs[rs];
            b      = regs[rt];
            val    = '0;
            ovf    = 1'b0;
            ok     = 1'b1;
            if (opcode == OP_SPECIAL) begin
                dest = rd;
                case (funct)
                    FN_SLL:  val = b << sa;
                    FN_ADD: begin
                        val = a + b;
                        ovf = (a[31] == b[31]) && (val[31] != a[31]);
                    end
                    FN_ADDU: val = a + b;
                    FN_SUB: begin
                        val = a - b;
                        ovf = (a[31] != b[31]) && (val[31] != a[31]);
                    end
                    FN_SUBU: val = a - b;
                    FN_AND:  val = a & b;
                    FN_OR:   val = a | b;
                    FN_XOR:  val = a ^ b;
                    default: ok = 1'b0;
                endcase
            end else begin
                dest = rt;
                case (opcode)
                    OP_ADDI: begin
                        val = a + simm;
                        ovf = (a[31] == simm[31]) && (val[31] != a[31]);
                    end
                    OP_ADDIU: val = a + simm;
                    OP_ANDI:  val = a & uimm;
                    OP_ORI:   val = a | uimm;
                    OP_XORI:  val = a ^ uimm;
                    OP_LUI:   val = uimm << 16;
                    default:  ok = 1'b0;
                endcase
            end
            r = '0;
            if (!ok) begin
                r.unsupported = 1'b1;
                return r;
            end
            // a trap or a write to register zero leaves the file unchanged
            wr = !ovf && (dest != '0);
            if (wr) regs[dest] = val;
            r.dest_index    = dest;
            r.dest_value    = wr ? val : '0;
            r.dest_written  = wr;
            r.overflow_trap = ovf;
            return r;
        endfunction

        // accepted instruction transaction
        function void note_instruction(logic [31:0] ins);
            exec_result_t e;
            e = execute(ins);
            n_instructions++;
            if (e.overflow_trap) n_traps++;
            if (e.unsupported) n_unsupported++;
            if (e.dest_written) n_writes++;
            pending_results.push_back(e);
        endfunction

        // accepted result transaction against the oldest expectation
        function void check_result(logic [39:0] data);
            exec_result_t act, e;
            act = exec_result_t'(data);
            n_results++;
            if (pending_results.size() == 0) begin
                $error("result with no instruction outstanding: %h", data);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (act.dest_index !== e.dest_index) begin
                $error("dest_index: expected %0d, got %0d", e.dest_index, act.dest_index);
                errors++;
            end
            if (act.dest_value !== e.dest_value) begin
                $error("dest_value: expected %h, got %h", e.dest_value, act.dest_value);
                errors++;
            end
            if (act.dest_written !== e.dest_written) begin
                $error("dest_written: expected %b, got %b", e.dest_written, act.dest_written);
                errors++;
            end
            if (act.overflow_trap !== e.overflow_trap) begin
                $error("overflow_trap: expected %b, got %b",
                       e.overflow_trap, act.overflow_trap);
                errors++;
            end
            if (act.unsupported !== e.unsupported) begin
                $error("unsupported: expected %b, got %b", e.unsupported, act.unsupported);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    alu_scoreboard sb = new();
    bit send_burst;
    bit recv_burst;

    mips_integer_alu_execute_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // instruction word builders
    function automatic logic [31:0] r_type(logic [5:0] funct, logic [4:0] rs, logic [4:0] rt,
                                           logic [4:0] rd, logic [4:0] sa);
        return {OP_SPECIAL, rs, rt, rd, sa, funct};
    endfunction

    function automatic logic [31:0] i_type(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                           logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // idle cycles for one transaction, with occasional stretches of none
    function automatic int unsigned draw_gap(inout bit burst);
        if ($urandom_range(0, 39) == 0) burst = !burst;
        return burst ? 0 : $urandom_range(0, 19);
    endfunction

    // register index biased toward a few registers so results feed each other
    function automatic logic [4:0] pick_reg();
        return ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 3)) : 5'($urandom);
    endfunction

    function automatic logic [15:0] pick_imm();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // random instruction: mostly the implemented subset, some raw words
    function automatic logic [31:0] random_instruction();
        logic [4:0]  rs, rt, rd, sa;
        logic [15:0] imm;
        rs  = pick_reg();
        rt  = pick_reg();
        rd  = pick_reg();
        sa  = 5'($urandom);
        imm = pick_imm();
        if ($urandom_range(0, 99) < 10) return $urandom;
        case ($urandom_range(0, 13))
            0:  return r_type(FN_SLL, rs, rt, rd, sa);
            1:  return r_type(FN_ADD, rs, rt, rd, sa);
            2:  return r_type(FN_ADDU, rs, rt, rd, sa);
            3:  return r_type(FN_SUB, rs, rt, rd, sa);
            4:  return r_type(FN_SUBU, rs, rt, rd, sa);
            5:  return r_type(FN_AND, rs, rt, rd, sa);
            6:  return r_type(FN_OR, rs, rt, rd, sa);
            7:  return r_type(FN_XOR, rs, rt, rd, sa);
            8:  return i_type(OP_ADDI, rs, rt, imm);
            9:  return i_type(OP_ADDIU, rs, rt, imm);
            10: return i_type(OP_ANDI, rs, rt, imm);
            11: return i_type(OP_ORI, rs, rt, imm);
            12: return i_type(OP_XORI, rs, rt, imm);
            default: return i_type(OP_LUI, rs, rt, imm);
        endcase
    endfunction

    // present one instruction and hold it until accepted; called at a falling edge
    task automatic send_instruction(logic [31:0] word);
        int unsigned gap;
        gap = draw_gap(send_burst);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        sb.note_instruction(word);
        @(negedge aclk);
    endtask

    // result side back-pressure
    task automatic accept_results();
        int unsigned gap;
        forever begin
            gap = draw_gap(recv_burst);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    endtask

    // result checking at the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // run limit
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        m_tready <= 1'b0;
        send_burst = 1'b0;
        recv_burst = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        fork
            accept_results();
        join_none

        // directed: extreme operands, every operation, traps, register zero, unused fields
        send_instruction(i_type(OP_LUI, 5'd0, 5'd1, 16'h7FFF));
        send_instruction(i_type(OP_ORI, 5'd1, 5'd1, 16'hFFFF));
        send_instruction(i_type(OP_LUI, 5'd0, 5'd2, 16'h8000));
        send_instruction(i_type(OP_ADDI, 5'd0, 5'd3, 16'hFFFF));
        send_instruction(i_type(OP_ADDIU, 5'd0, 5'd4, 16'h0001));
        send_instruction(r_type(FN_ADD, 5'd1, 5'd4, 5'd5, 5'd0));
        send_instruction(r_type(FN_ADDU, 5'd1, 5'd4, 5'd5, 5'd0));
        send_instruction(r_type(FN_SUB, 5'd2, 5'd4, 5'd6, 5'd0));
        send_instruction(r_type(FN_SUBU, 5'd2, 5'd4, 5'd6, 5'd0));
        send_instruction(r_type(FN_SUB, 5'd1, 5'd2, 5'd17, 5'd0));
        send_instruction(i_type(OP_ADDI, 5'd1, 5'd7, 16'h0001));
        send_instruction(i_type(OP_ADDI, 5'd2, 5'd7, 16'h8000));
        send_instruction(r_type(FN_ADD, 5'd3, 5'd4, 5'd0, 5'd0));
        send_instruction(i_type(OP_ADDIU, 5'd1, 5'd0, 16'h0005));
        send_instruction(r_type(FN_SLL, 5'd31, 5'd3, 5'd8, 5'd31));
        send_instruction(r_type(FN_SLL, 5'd31, 5'd8, 5'd8, 5'd0));
        send_instruction(r_type(FN_AND, 5'd1, 5'd3, 5'd9, 5'd0));
        send_instruction(r_type(FN_OR, 5'd2, 5'd4, 5'd10, 5'd0));
        send_instruction(r_type(FN_XOR, 5'd1, 5'd3, 5'd31, 5'd0));
        send_instruction(i_type(OP_ANDI, 5'd31, 5'd12, 16'hFFFF));
        send_instruction(i_type(OP_XORI, 5'd3, 5'd14, 16'hFFFF));
        send_instruction(i_type(OP_LUI, 5'd31, 5'd15, 16'hFFFF));
        send_instruction(r_type(FN_ADD, 5'd3, 5'd3, 5'd16, 5'd31));
        send_instruction(i_type(OP_LW, 5'd1, 5'd2, 16'h0004));
        send_instruction(r_type(FN_UNASSIGNED, 5'd1, 5'd2, 5'd3, 5'd0));
        send_instruction(32'hFFFF_FFFF);
        send_instruction(32'h0000_0000);

        // random part
        repeat (RANDOM_ITEMS) send_instruction(random_instruction());
        s_tvalid <= 1'b0;

        // drain outstanding results, then allow for pipeline latency
        for (int unsigned n = 0; n < DRAIN_LIMIT && sb.pending_results.size() > 0; n++)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.pending_results.size() > 0) begin
            $error("%0d expected results never arrived", sb.pending_results.size());
            sb.errors++;
        end

        $display("run covered %0d instructions and %0d results: %0d register writes,",
                 sb.n_instructions, sb.n_results, sb.n_writes);
        $display("%0d overflow traps and %0d unsupported words", sb.n_traps, sb.n_unsupported);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
